// File: rtl/imptt_pkg.sv
package imptt_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_EDIT   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_EXEC   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] user_id;
        logic [9:0]  task_id;
        logic [31:0] priority_req;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] served_user;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] user;
        logic [31:0] prio;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic start_scan;
        logic scan_step;
        logic modify;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_exec;
        logic in_range;
        logic empty;
        logic clear_last;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/imptt_ctrl.sv
module imptt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  imptt_pkg::sts_t  sts,
    output imptt_pkg::cmd_t  cmd
);
    import imptt_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (sts.in_exec)
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = sts.empty ? ST_DONE : ST_SCAN;
                    end
                    else if (sts.in_range)
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                cmd.modify = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/imptt_dpath.sv
module imptt_dpath #(
    parameter int TASK_SLOTS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  imptt_pkg::req_t  req,
    input  imptt_pkg::cmd_t  cmd,
    output imptt_pkg::sts_t  sts,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output imptt_pkg::rsp_t  rsp
);
    import imptt_pkg::*;

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
    localparam logic [16:0] SLOTS_C = 17'(TASK_SLOTS);

    entry_t mem [TASK_SLOTS];

    logic [IDX_W+9:0] in_idx_ext;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             take_best;

    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic [1:0]       item_action_reg;
    logic [15:0]      item_user_reg;
    logic [IDX_W-1:0] item_idx_reg;
    logic [31:0]      item_prio_reg;

    logic [IDX_W-1:0] scan_addr_reg;
    logic [IDX_W-1:0] scan_addr_next;
    logic             have_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [15:0]      best_user_reg;
    logic [31:0]      best_prio_reg;

    logic [CNT_W-1:0] live_count_reg;
    logic [CNT_W-1:0] live_count_next;

    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;

    assign in_idx_ext = {{IDX_W{1'b0}}, req.task_id};
    assign in_idx     = in_idx_ext[IDX_W-1:0];

    assign sts.in_exec    = (req.action == ACT_EXEC);
    assign sts.in_range   = ({7'd0, req.task_id} < SLOTS_C);
    assign sts.empty      = (live_count_reg == '0);
    assign sts.clear_last = (scan_addr_reg == LAST_IDX);
    assign sts.scan_last  = (rd_idx_reg == LAST_IDX);
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        if (cmd.start_scan)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan_step)
        begin
            rd_addr = scan_addr_reg;
        end
        else
        begin
            rd_addr = in_idx;
        end
    end

    // A read-modify-write of an entry keeps the fields the transaction leaves alone.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = scan_addr_reg;
        wr_data = '0;
        if (cmd.clear_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.modify)
        begin
            wr_addr = item_idx_reg;
            case (item_action_reg)
                ACT_ADD:
                begin
                    wr_en   = 1'b1;
                    wr_data = '{valid: 1'b1, user: item_user_reg, prio: item_prio_reg};
                end
                ACT_EDIT:
                begin
                    wr_en   = rd_data_reg.valid;
                    wr_data = '{valid: 1'b1, user: rd_data_reg.user, prio: item_prio_reg};
                end
                ACT_REMOVE:
                begin
                    wr_en   = rd_data_reg.valid;
                    wr_data = '{valid: 1'b0, user: rd_data_reg.user,
                                prio: rd_data_reg.prio};
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.finish)
        begin
            wr_en   = have_reg;
            wr_addr = best_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_action_reg <= req.action;
            item_user_reg   <= req.user_id;
            item_idx_reg    <= in_idx;
            item_prio_reg   <= req.priority_req;
        end
    end

    // The >= comparison lets a later, higher task id win a tie.
    assign take_best = cmd.scan_step && rd_data_reg.valid
                       && (!have_reg || (rd_data_reg.prio >= best_prio_reg));

    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_user_reg <= rd_data_reg.user;
            best_prio_reg <= rd_data_reg.prio;
        end
    end

    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        if (cmd.start_scan)
        begin
            scan_addr_next = IDX_W'(1);
        end
        else if (cmd.clear_wr || cmd.scan_step)
        begin
            scan_addr_next = scan_addr_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        live_count_next = live_count_reg;
        if (cmd.modify)
        begin
            if ((item_action_reg == ACT_ADD) && !rd_data_reg.valid)
            begin
                live_count_next = live_count_reg + CNT_W'(1);
            end
            else if ((item_action_reg == ACT_REMOVE) && rd_data_reg.valid)
            begin
                live_count_next = live_count_reg - CNT_W'(1);
            end
        end
        else if (cmd.finish && have_reg)
        begin
            live_count_next = live_count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            have_reg       <= 1'b0;
            live_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            scan_addr_reg  <= scan_addr_next;
            live_count_reg <= live_count_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cmd.start_scan)
            begin
                have_reg <= 1'b0;
            end
            else if (take_best)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.found       <= have_reg;
            rsp_reg.served_user <= have_reg ? best_user_reg : 16'd0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/indexed_max_priority_task_table.sv
// Task table indexed by task id, with an execute-top-priority operation.
// Request channel (req_valid, req_stall, req): one transaction carries an action
// (add, edit priority, remove, execute top) with user, task id and priority.
// Response channel (rsp_valid, rsp_stall, rsp): only an execute-top transaction
// gives a response, with found and served_user (zero when the table is empty).
// Add, edit and remove first read the entry, then write it.
// Execute top scans the table memory, reading every entry once through its
// read port; on an empty table the scan is skipped.
// The request side is stalled while a transaction is in progress.
// After reset the block clears the valid marks with a pass over every entry,
// one entry per cycle, and stalls the request side until it is done.
// A response waits in an output register while rsp_stall is high; further
// add, edit and remove transactions are still taken meanwhile, and a second
// execute top holds its response until the register is free.
module indexed_max_priority_task_table #(
    parameter int TASK_SLOTS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  imptt_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output imptt_pkg::rsp_t  rsp
);
    import imptt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    imptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    imptt_dpath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_wr, cmd.modify, cmd.scan_step, cmd.finish}))
        else $error("more than one datapath command at once");

    a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall |-> !(cmd.clear_wr || cmd.modify || cmd.scan_step || cmd.finish))
        else $error("datapath busy while requests are taken");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid)
        else $error("finished execute gave no response");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(rsp_valid && rsp_stall))
        else $error("response overwritten while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found) |-> (rsp.served_user == 16'd0))
        else $error("not-found response carries a user");
`endif

endmodule

// File: tb/sv/imptt_checker.sv
`timescale 1ns / 100ps

module imptt_checker #(
    parameter int TASK_SLOTS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  imptt_pkg::req_t req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  imptt_pkg::rsp_t rsp,
    output int              mismatches,
    output int              outstanding,
    output int              responses_seen,
    output int              hits
);

    import imptt_pkg::*;

    logic        slot_live  [TASK_SLOTS];
    logic [15:0] slot_owner [TASK_SLOTS];
    logic [31:0] slot_rank  [TASK_SLOTS];

    rsp_t served_q[$];

    // Update the table copy for one accepted request; an execute-top transaction
    // queues the response that the block owes.
    task automatic apply_request(input req_t item);
        int   best;
        logic have;
        rsp_t res;
        best = 0;
        have = 1'b0;
        case (item.action)
            ACT_ADD:
            begin
                if (int'(item.task_id) < TASK_SLOTS)
                begin
                    slot_live[item.task_id]  = 1'b1;
                    slot_owner[item.task_id] = item.user_id;
                    slot_rank[item.task_id]  = item.priority_req;
                end
            end
            ACT_EDIT:
            begin
                if (int'(item.task_id) < TASK_SLOTS && slot_live[item.task_id])
                    slot_rank[item.task_id] = item.priority_req;
            end
            ACT_REMOVE:
            begin
                if (int'(item.task_id) < TASK_SLOTS)
                    slot_live[item.task_id] = 1'b0;
            end
            ACT_EXEC:
            begin
                // Greater-or-equal lets the higher task id win a tie.
                for (int i = 0; i < TASK_SLOTS; i++)
                begin
                    if (slot_live[i] && (!have || slot_rank[i] >= slot_rank[best]))
                    begin
                        best = i;
                        have = 1'b1;
                    end
                end
                res.found       = have;
                res.served_user = have ? slot_owner[best] : 16'd0;
                if (have)
                    slot_live[best] = 1'b0;
                served_q.push_back(res);
            end
        endcase
    endtask

    task automatic check_response(input rsp_t got);
        rsp_t want;
        responses_seen++;
        if (got.found)
            hits++;
        if (served_q.size() == 0)
        begin
            $error("Response with no execute-top outstanding: found %0d served_user 0x%04h",
                   got.found, got.served_user);
            mismatches++;
        end
        else
        begin
            want = served_q.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                mismatches++;
            end
            if (got.served_user !== want.served_user)
            begin
                $error("served_user: expected 0x%04h, got 0x%04h",
                       want.served_user, got.served_user);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
                slot_live[i] = 1'b0;
            served_q.delete();
            mismatches     = 0;
            outstanding    = 0;
            responses_seen = 0;
            hits           = 0;
        end
        else
        begin
            // The response leaving now belongs to an earlier transaction, so
            // retire it before taking a new request at the same edge.
            if (rsp_valid && !rsp_stall)
                check_response(rsp);
            if (req_valid && !req_stall)
                apply_request(req);
            outstanding = served_q.size();
        end
    end

endmodule

// File: tb/sv/tb_indexed_max_priority_task_table.sv
`timescale 1ns / 100ps

module tb_indexed_max_priority_task_table;

    import imptt_pkg::*;

    localparam int TASK_SLOTS   = 1024;
    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 556;
    localparam int PHASES       = 4;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int idle_pct;
    int stall_pct;
    int pool_base;
    int sent;
    int exec_sent;
    int quiet_cycles;

    int mismatches;
    int outstanding;
    int responses_seen;
    int hits;

    indexed_max_priority_task_table #(
        .TASK_SLOTS(TASK_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    imptt_checker #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .responses_seen(responses_seen),
        .hits          (hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);

    // Ends the run when neither channel has moved a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic req_t make_req(input logic [1:0] act, input logic [15:0] user,
                                      input logic [9:0] tid, input logic [31:0] prio);
        req_t item;
        item.action       = act;
        item.user_id      = user;
        item.task_id      = tid;
        item.priority_req = prio;
        return item;
    endfunction

    // Most task ids fall in a small window so that edits, removes and re-adds
    // hit live entries; small priorities make ties common.
    function automatic req_t random_req();
        req_t item;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            item.action = ACT_ADD;
        else if (pick < 56)
            item.action = ACT_EDIT;
        else if (pick < 70)
            item.action = ACT_REMOVE;
        else
            item.action = ACT_EXEC;
        item.user_id = 16'($urandom);
        if ($urandom_range(0, 99) < 75)
            item.task_id = 10'(pool_base + int'($urandom_range(0, 31)));
        else
            item.task_id = 10'($urandom_range(0, TASK_SLOTS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            item.priority_req = $urandom_range(0, 7);
        else if (pick < 50)
        begin
            case ($urandom_range(0, 3))
                0: item.priority_req = 32'h0000_0000;
                1: item.priority_req = 32'hFFFF_FFFF;
                2: item.priority_req = 32'h8000_0000;
                default: item.priority_req = 32'h7FFF_FFFF;
            endcase
        end
        else
            item.priority_req = $urandom;
        return item;
    endfunction

    task automatic send_req(input req_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
        if (item.action == ACT_EXEC)
            exec_sent++;
    endtask

    task automatic drain_responses();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        pool_base    = 0;
        sent         = 0;
        exec_sent    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty table, extreme fields, overwrite of a live entry,
        // ties, unsigned ordering and ignored edits and removes.
        send_req(make_req(ACT_EXEC,   16'h0000, 10'd0,   32'h0000_0000));
        send_req(make_req(ACT_ADD,    16'h0000, 10'd0,   32'h0000_0000));
        send_req(make_req(ACT_ADD,    16'hFFFF, 10'd1023, 32'hFFFF_FFFF));
        send_req(make_req(ACT_ADD,    16'hA5A5, 10'd512, 32'hFFFF_FFFF));
        send_req(make_req(ACT_EXEC,   16'h1234, 10'd5,   32'h0000_0001));
        send_req(make_req(ACT_ADD,    16'h5A5A, 10'd512, 32'h0000_0005));
        send_req(make_req(ACT_EDIT,   16'hFFFF, 10'd700, 32'hFFFF_FFFF));
        send_req(make_req(ACT_REMOVE, 16'hFFFF, 10'd701, 32'hFFFF_FFFF));
        send_req(make_req(ACT_EDIT,   16'hBEEF, 10'd0,   32'h8000_0000));
        send_req(make_req(ACT_ADD,    16'h1234, 10'd3,   32'h7FFF_FFFF));
        send_req(make_req(ACT_EXEC,   16'h0000, 10'd0,   32'h0000_0000));
        send_req(make_req(ACT_REMOVE, 16'hDEAD, 10'd3,   32'h1234_5678));
        send_req(make_req(ACT_EXEC,   16'h0000, 10'd0,   32'h0000_0000));
        send_req(make_req(ACT_EXEC,   16'h0000, 10'd0,   32'h0000_0000));
        send_req(make_req(ACT_ADD,    16'h0001, 10'd10,  32'h0000_0007));
        send_req(make_req(ACT_ADD,    16'h0002, 10'd20,  32'h0000_0007));
        send_req(make_req(ACT_EXEC,   16'hFFFF, 10'd1023, 32'hFFFF_FFFF));
        send_req(make_req(ACT_EXEC,   16'h0000, 10'd0,   32'h0000_0000));
        send_req(make_req(ACT_EXEC,   16'h0000, 10'd0,   32'h0000_0000));
        send_req(make_req(ACT_REMOVE, 16'h0000, 10'd10,  32'h0000_0000));
        // Hold the sender until every response has arrived.
        drain_responses();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 72;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 72;
                end
                default:
                begin
                    idle_pct  = 30;
                    stall_pct = 30;
                end
            endcase
            pool_base = $urandom_range(0, TASK_SLOTS - 32);
            repeat (RANDOM_ITEMS / PHASES)
                send_req(random_req());
            drain_responses();
        end

        stall_pct = 0;
        // Leave room for a stray response from the longest scan.
        repeat (TASK_SLOTS + 8) @(posedge clk);

        $display("Sent %0d requests, %0d of them execute-top, under four mixes of idling.",
                 sent, exec_sent);
        $display("Checked %0d responses: %0d served a task, %0d found the table empty.",
                 responses_seen, hits, responses_seen - hits);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
